// ===== src/sorted_priority_queue_assert.svh =====
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Clocked on clk and switched off while rst_n is low.
`define SPQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted_priority_queue check failed");

// Clocked on clk and also checked while reset is held.
`define SPQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sorted_priority_queue reset check failed");

`endif

// ===== src/spq_pkg.sv =====
// Package with the types, codes and defaults of the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TAG_WIDTH_DEF = 16;

    localparam int PRI_WIDTH    = 8;
    localparam int TAG_PORT_W   = 16;
    localparam int OCC_WIDTH    = 5;
    localparam int STATUS_WIDTH = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

    // Shift controls broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell #(
    parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire spq_pkg::cell_ctl_t             ctl,
    input  wire logic                           occupied,
    input  wire logic [spq_pkg::PRI_WIDTH-1:0]  new_pri,
    input  wire logic [TAG_WIDTH-1:0]           new_tag,
    input  wire logic                           left_goes,
    input  wire logic [spq_pkg::PRI_WIDTH-1:0]  left_pri,
    input  wire logic [TAG_WIDTH-1:0]           left_tag,
    input  wire logic [spq_pkg::PRI_WIDTH-1:0]  right_pri,
    input  wire logic [TAG_WIDTH-1:0]           right_tag,
    output logic                                goes,
    output logic [spq_pkg::PRI_WIDTH-1:0]       pri,
    output logic [TAG_WIDTH-1:0]                tag
);

    logic [spq_pkg::PRI_WIDTH-1:0] pri_reg;
    logic [spq_pkg::PRI_WIDTH-1:0] pri_next;
    logic [TAG_WIDTH-1:0]          tag_reg;
    logic [TAG_WIDTH-1:0]          tag_next;

    // The new entry belongs at or before this slot when the slot is free or
    // holds a strictly larger priority. Equal priorities keep the older entry ahead.
    assign goes = !occupied || (pri_reg > new_pri);

    always_comb
    begin
        pri_next = pri_reg;
        tag_next = tag_reg;
        if (ctl.insert)
        begin
            if (left_goes)
            begin
                pri_next = left_pri;
                tag_next = left_tag;
            end
            else if (goes)
            begin
                pri_next = new_pri;
                tag_next = new_tag;
            end
        end
        else if (ctl.remove)
        begin
            pri_next = right_pri;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        tag_reg <= tag_next;
    end

    assign pri = pri_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell row, entry count and result register.
//
//   channel   handshake              payload
//   request   req_valid, req_ready   cmd, priority_req, tag
//   result    rsp_valid, rsp_ready   out_valid, out_priority, out_tag, status, occupancy
//
// One request is taken per cycle while no result is stalled; its result is registered and shows in the next cycle.
// Every cell compares its entry with the new priority in parallel, so an insert or a
// remove is done by that compare and a neighbor shift.
// Reset clears the entry count and rsp_valid; the slot contents and result payload are not reset.
// While a result waits with rsp_ready low, req_ready is low and the row holds.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic                              cmd,
    input  wire logic [spq_pkg::PRI_WIDTH-1:0]     priority_req,
    input  wire logic [spq_pkg::TAG_PORT_W-1:0]    tag,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic                                   out_valid,
    output logic [spq_pkg::PRI_WIDTH-1:0]          out_priority,
    output logic [spq_pkg::TAG_PORT_W-1:0]         out_tag,
    output logic [spq_pkg::STATUS_WIDTH-1:0]       status,
    output logic [spq_pkg::OCC_WIDTH-1:0]          occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [spq_pkg::PRI_WIDTH-1:0]        out_priority_reg;
    logic [spq_pkg::PRI_WIDTH-1:0]        out_priority_next;
    logic [spq_pkg::TAG_PORT_W-1:0]       out_tag_reg;
    logic [spq_pkg::TAG_PORT_W-1:0]       out_tag_next;
    logic [spq_pkg::STATUS_WIDTH-1:0]     status_reg;
    logic [spq_pkg::STATUS_WIDTH-1:0]     status_next;
    logic [spq_pkg::OCC_WIDTH-1:0]        occupancy_reg;
    logic [spq_pkg::OCC_WIDTH-1:0]        occupancy_next;

    logic               accept;
    logic               is_insert;
    logic               full;
    logic               empty;
    spq_pkg::cell_ctl_t ctl;
    logic [TAG_WIDTH-1:0] new_tag;

    logic                          cell_goes [DEPTH];
    logic [spq_pkg::PRI_WIDTH-1:0] cell_pri  [DEPTH];
    logic [TAG_WIDTH-1:0]          cell_tag  [DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_insert = (cmd == spq_pkg::CMD_INSERT);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == CW'(0));
    assign new_tag   = TAG_WIDTH'(tag);

    assign ctl.insert = accept && is_insert && !full;
    assign ctl.remove = accept && !is_insert && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                          l_goes;
            logic [spq_pkg::PRI_WIDTH-1:0] l_pri;
            logic [TAG_WIDTH-1:0]          l_tag;
            logic [spq_pkg::PRI_WIDTH-1:0] r_pri;
            logic [TAG_WIDTH-1:0]          r_tag;

            if (i == 0)
            begin : g_first
                assign l_goes = 1'b0;
                assign l_pri  = priority_req;
                assign l_tag  = new_tag;
            end
            else
            begin : g_inner_l
                assign l_goes = cell_goes[i-1];
                assign l_pri  = cell_pri[i-1];
                assign l_tag  = cell_tag[i-1];
            end

            // The last slot has nothing behind it; whatever it loads on a remove
            // lies beyond the count and is never read.
            if (i == DEPTH - 1)
            begin : g_last
                assign r_pri = priority_req;
                assign r_tag = new_tag;
            end
            else
            begin : g_inner_r
                assign r_pri = cell_pri[i+1];
                assign r_tag = cell_tag[i+1];
            end

            spq_cell #(
                .TAG_WIDTH (TAG_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (count_reg > CW'(i)),
                .new_pri   (priority_req),
                .new_tag   (new_tag),
                .left_goes (l_goes),
                .left_pri  (l_pri),
                .left_tag  (l_tag),
                .right_pri (r_pri),
                .right_tag (r_tag),
                .goes      (cell_goes[i]),
                .pri       (cell_pri[i]),
                .tag       (cell_tag[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next    = ctl.remove;
        out_priority_next = '0;
        out_tag_next      = '0;
        status_next       = spq_pkg::ST_OK;
        occupancy_next    = spq_pkg::OCC_WIDTH'(count_next);
        if (ctl.remove)
        begin
            out_priority_next = cell_pri[0];
            out_tag_next      = spq_pkg::TAG_PORT_W'(cell_tag[0]);
        end
        if (is_insert && full)
        begin
            status_next = spq_pkg::ST_FULL;
        end
        else if (!is_insert && empty)
        begin
            status_next = spq_pkg::ST_EMPTY;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg    <= out_valid_next;
            out_priority_reg <= out_priority_next;
            out_tag_reg      <= out_tag_next;
            status_reg       <= status_next;
            occupancy_reg    <= occupancy_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_priority = out_priority_reg;
    assign out_tag      = out_tag_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to its top level.
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              cmd,
    input wire logic [spq_pkg::PRI_WIDTH-1:0]     priority_req,
    input wire logic [spq_pkg::TAG_PORT_W-1:0]    tag,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic                              out_valid,
    input wire logic [spq_pkg::PRI_WIDTH-1:0]     out_priority,
    input wire logic [spq_pkg::TAG_PORT_W-1:0]    out_tag,
    input wire logic [spq_pkg::STATUS_WIDTH-1:0]  status,
    input wire logic [spq_pkg::OCC_WIDTH-1:0]     occupancy
);

    // No result is shown while reset is held.
    `SPQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !rsp_valid)

    // An accepted request always produces a result in the next cycle.
    `SPQ_ASSERT(a_req_to_rsp, (req_valid && req_ready) |=> rsp_valid)

    // A stalled result blocks new requests.
    `SPQ_ASSERT(a_stall_blocks, (rsp_valid && !rsp_ready) |-> !req_ready)

    // A delivered head entry always comes with an ok status.
    `SPQ_ASSERT(a_pop_ok, (rsp_valid && out_valid) |-> (status == spq_pkg::ST_OK))

    // A remove on an empty queue leaves it empty.
    `SPQ_ASSERT(a_empty_zero,
        (rsp_valid && (status == spq_pkg::ST_EMPTY)) |-> (occupancy == '0 && !out_valid))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
